// ===== rtl/three_term_recurrence_checksum_unit_defines.svh =====
// Assertion macros shared by the checksum unit RTL.
`ifndef THREE_TERM_RECURRENCE_CHECKSUM_UNIT_DEFINES_SVH
`define THREE_TERM_RECURRENCE_CHECKSUM_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTRC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ttrc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ttrc: next-cycle check failed");

`endif

// ===== rtl/ttrc_pkg.sv =====
// Types and constants of the three-term recurrence checksum unit.
`default_nettype none

package ttrc_pkg;

	// Recurrence state carried from one byte to the next.
	typedef struct packed {
		logic [15:0] earlier;
		logic [15:0] current;
		logic [7:0]  pos;
	} ttrc_state_t;

	localparam logic [7:0]  ALPHA_STEP   = 8'd17;
	localparam logic [7:0]  BETA_STEP    = 8'd31;
	localparam logic [15:0] START_OFFSET = 16'd7;
	localparam logic [15:0] FOLD_MOD     = 16'hFFFF;
	// 257 * 65535: lifts the worst negative difference above zero, and is 0 mod 65535.
	localparam logic [25:0] FOLD_BIAS    = 26'd16842495;

	localparam ttrc_state_t RESET_STATE = '{earlier: 16'd1, current: 16'd0, pos: 8'd0};

endpackage

`default_nettype wire

// ===== rtl/three_term_recurrence_checksum_unit.sv =====
// Top level of the three-term recurrence checksum unit.
//
// A message arrives one byte per transfer on the input channel (data_byte,
// last_byte, in_valid, in_stall). After the byte marked last, one 16-bit
// checksum leaves on the output channel (checksum, out_valid, out_stall).
// A transfer happens at a rising edge where valid is high and stall is low.
//
// Throughput is one byte per cycle while in_stall is low: each byte is
// registered, then one recurrence step (two small multiplies and a mod-65535
// fold) updates the state in the following cycle, in time for the next byte.
// The checksum is loaded into the output register, with out_valid, when the
// last byte leaves the input register. The output register lets new bytes
// flow while a checksum waits.
//
// Reset clears the state to the start of a message and empties both
// registers. If the receiver stalls while a checksum waits, bytes keep
// flowing until the next last byte reaches the input register; it then
// holds there and in_stall rises until the checksum is taken.
`default_nettype none

module three_term_recurrence_checksum_unit
	import ttrc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      checksum
);

	`include "three_term_recurrence_checksum_unit_defines.svh"

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	ttrc_state_t state_q;
	logic        at_start_q;
	ttrc_state_t step_next;
	logic        out_valid_q;
	logic [15:0] checksum_q;
	logic        advance;
	logic        in_xfer;

	// The stage moves on unless it holds a last byte and the result slot is blocked.
	assign advance  = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ttrc_step u_step (
		.at_start   (at_start_q),
		.data_byte  (byte_s1),
		.cur_state  (state_q),
		.next_state (step_next)
	);

	// Recurrence state, restarted after each last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= RESET_STATE;
			at_start_q <= 1'b1;
		end else if (advance) begin
			if (last_s1) begin
				state_q    <= RESET_STATE;
				at_start_q <= 1'b1;
			end else begin
				state_q    <= step_next;
				at_start_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			checksum_q <= step_next.current;
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

	// Checks on the recurrence and the flow control.
	`TTRC_ASSERT_SAME(a_fold_range, valid_s1 && !at_start_q, step_next.current != FOLD_MOD)
	`TTRC_ASSERT_NEXT(a_restart, advance && last_s1, at_start_q && out_valid_q)
	`TTRC_ASSERT_SAME(a_stall_cause, in_stall, valid_s1 && last_s1 && out_valid_q && out_stall)
	`TTRC_ASSERT_SAME(a_start_state, at_start_q, state_q == RESET_STATE)

endmodule

`default_nettype wire

// ===== rtl/ttrc_step.sv =====
// One recurrence step: coefficients, the two products and the mod-65535 fold.
`default_nettype none

module ttrc_step
	import ttrc_pkg::*;
(
	input  wire logic        at_start,
	input  wire logic [7:0]  data_byte,
	input  wire ttrc_state_t cur_state,
	output ttrc_state_t      next_state
);

	logic [7:0]  alpha;
	logic [7:0]  beta;
	logic [8:0]  factor;
	logic [24:0] prod_cur;
	logic [23:0] prod_early;
	logic        negative;
	logic [25:0] biased;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic [15:0] reduced;

	// Position coefficients, both taken modulo 256.
	assign alpha  = 8'(cur_state.pos * ALPHA_STEP);
	assign beta   = 8'(cur_state.pos * BETA_STEP);
	assign factor = {1'b0, data_byte} + {1'b0, alpha};

	// The two independent products, with both operands widened to the product width.
	assign prod_cur   = {16'd0, factor} * {9'd0, cur_state.current};
	assign prod_early = {16'd0, beta} * {8'd0, cur_state.earlier};

	// A negative 64-bit wrap adds one after reduction; the bias keeps the value positive.
	assign negative = ({1'b0, prod_cur} < {2'b00, prod_early});
	assign biased   = {1'b0, prod_cur} + FOLD_BIAS + {25'd0, negative} - {2'b00, prod_early};

	// End-around fold of the upper bits, then one final correction.
	assign fold1   = {1'b0, biased[15:0]} + {7'd0, biased[25:16]};
	assign fold2   = fold1[15:0] + {15'd0, fold1[16]};
	assign reduced = (fold2 == FOLD_MOD) ? 16'd0 : fold2;

	// The first byte seeds the recurrence; later bytes shift the terms along.
	always_comb begin
		if (at_start) begin
			next_state.earlier = 16'd1;
			next_state.current = {8'd0, data_byte} + START_OFFSET;
			next_state.pos     = 8'd1;
		end else begin
			next_state.earlier = cur_state.current;
			next_state.current = reduced;
			next_state.pos     = cur_state.pos + 8'd1;
		end
	end

endmodule

`default_nettype wire
